/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the delay generator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define DPG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define DPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dpg_pkg.sv */
// ----------------------------------------------------------------------------
// dpg_pkg
// Types and constants shared by the delayed pulse generator modules.
// ----------------------------------------------------------------------------
package dpg_pkg;

	// Operation codes of a command word
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_EDGE   = 2'd1;
	localparam logic [1:0] OP_ARM    = 2'd2;
	localparam logic [1:0] OP_DISARM = 2'd3;

	// Edge modes; any other code means both edges
	localparam logic [1:0] EDGE_RISE = 2'd0;
	localparam logic [1:0] EDGE_FALL = 2'd1;

	localparam int SETUP_BITS     = 58;
	localparam int FIELD_BITS     = 24;
	localparam int PIN_BITS       = 5;
	localparam int COUNT_BITS     = 32;
	localparam int STAMP_BITS     = 64;
	localparam int NUM_SETUP_REGS = 4;
	localparam int REG_INDEX_BITS = 2;
	localparam int OUT_CHANNELS   = 4;
	localparam int PIN_BASE       = 2;

	localparam logic [FIELD_BITS-1:0] RESET_WIDTH = 24'd100;

	// Channel setup register, packed as delay[23:0], width[47:24], pin[52:48],
	// edge mode[54:53], enable[55], idle level[56], active level[57]
	typedef struct packed {
		logic                  act_level;
		logic                  idle_level;
		logic                  enable;
		logic [1:0]            edge_sel;
		logic [PIN_BITS-1:0]   pin;
		logic [FIELD_BITS-1:0] width;
		logic [FIELD_BITS-1:0] delay;
	} setup_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [PIN_BITS-1:0] event_pin;
		logic                rise_seen;
		logic                fall_seen;
		logic [1:0]          status_channel;
	} cmd_t;

	typedef struct packed {
		logic [OUT_CHANNELS-1:0] output_levels;
		logic [OUT_CHANNELS-1:0] pending_flags;
		logic                    is_armed;
		logic                    accepted;
		logic [COUNT_BITS-1:0]   channel_event_count;
		logic [STAMP_BITS-1:0]   channel_last_event_time;
	} rsp_t;

	// Per-channel controls, already qualified by the pipeline advancing
	typedef struct packed {
		logic tick;
		logic cancel;
	} chan_ctl_t;

	// Setup fields the edge matcher needs
	typedef struct packed {
		logic                enable;
		logic [1:0]          edge_sel;
		logic [PIN_BITS-1:0] pin;
	} match_cfg_t;

	// Channel state after the current word
	typedef struct packed {
		logic                  level;
		logic                  pending;
		logic [COUNT_BITS-1:0] count;
		logic [STAMP_BITS-1:0] stamp;
	} chan_stat_t;

endpackage

/* design/dpg_match.sv */
// ----------------------------------------------------------------------------
// dpg_match
// Routes a pin edge word to the first channel whose pin, enable and edge mode fit.
// ----------------------------------------------------------------------------
module dpg_match #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                                      edge_in,
	input  logic                                      armed,
	input  logic [dpg_pkg::PIN_BITS-1:0]              event_pin,
	input  logic                                      rise_seen,
	input  logic                                      fall_seen,
	input  dpg_pkg::match_cfg_t [NUM_CHANNELS-1:0]    cfg,
	input  logic [NUM_CHANNELS-1:0]                   pending,
	output logic [NUM_CHANNELS-1:0]                   hit,
	output logic                                      accepted
);

	logic [NUM_CHANNELS-1:0] fits;

	always_comb begin
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			case (cfg[ch].edge_sel)
				dpg_pkg::EDGE_RISE: fits[ch] = rise_seen;
				dpg_pkg::EDGE_FALL: fits[ch] = fall_seen;
				default:            fits[ch] = rise_seen | fall_seen;
			endcase
			fits[ch] = fits[ch] & cfg[ch].enable & (cfg[ch].pin == event_pin);
		end
	end

	// The first fitting channel takes the word; if it is busy, drop the word
	always_comb begin
		logic found;
		found = 1'b0;
		hit   = '0;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			if (!found && fits[ch]) begin
				found = 1'b1;
				hit[ch] = edge_in & armed & ~pending[ch];
			end
		end
		accepted = |hit;
	end

endmodule

/* design/dpg_channel.sv */
// ----------------------------------------------------------------------------
// dpg_channel
// One delay channel: setup register, delay and pulse countdown, event statistics.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpg_channel #(
	parameter int CH_INDEX        = 0,
	parameter int TICK_COUNT_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr,
	input  logic [dpg_pkg::SETUP_BITS-1:0]   cfg_data,
	input  dpg_pkg::chan_ctl_t               ctl,
	input  logic                             hit,
	input  logic [dpg_pkg::STAMP_BITS-1:0]   tick_time,
	output dpg_pkg::match_cfg_t              mcfg,
	output logic                             pending,
	output dpg_pkg::chan_stat_t              stat
);

	localparam dpg_pkg::setup_t SETUP_RESET = '{
		act_level:  1'b1,
		idle_level: 1'b0,
		enable:     1'b1,
		edge_sel:   dpg_pkg::EDGE_RISE,
		pin:        dpg_pkg::PIN_BITS'(CH_INDEX + dpg_pkg::PIN_BASE),
		width:      dpg_pkg::RESET_WIDTH,
		delay:      '0
	};

	dpg_pkg::setup_t               setup_q;
	logic                          pending_q, pending_d;
	logic                          phase_q, phase_d;
	logic [TICK_COUNT_BITS-1:0]    rem_q, rem_d, rem_dec;
	logic [dpg_pkg::COUNT_BITS-1:0] count_q, count_d;
	logic [dpg_pkg::STAMP_BITS-1:0] stamp_q, stamp_d;
	logic [TICK_COUNT_BITS-1:0]    delay_sat, width_sat;

	// Saturate the 24-bit fields to the counter width
	generate
		if (TICK_COUNT_BITS >= dpg_pkg::FIELD_BITS) begin : g_wide
			assign delay_sat = TICK_COUNT_BITS'(setup_q.delay);
			assign width_sat = TICK_COUNT_BITS'(setup_q.width);
		end else begin : g_narrow
			assign delay_sat = (|setup_q.delay[dpg_pkg::FIELD_BITS-1:TICK_COUNT_BITS]) ?
				'1 : setup_q.delay[TICK_COUNT_BITS-1:0];
			assign width_sat = (|setup_q.width[dpg_pkg::FIELD_BITS-1:TICK_COUNT_BITS]) ?
				'1 : setup_q.width[TICK_COUNT_BITS-1:0];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q <= SETUP_RESET;
		end else if (cfg_wr) begin
			setup_q <= dpg_pkg::setup_t'(cfg_data);
		end
	end

	assign rem_dec = (rem_q == '0) ? '0 : rem_q - TICK_COUNT_BITS'(1);

	always_comb begin
		pending_d = pending_q;
		phase_d   = phase_q;
		rem_d     = rem_q;
		count_d   = count_q;
		stamp_d   = stamp_q;
		if (ctl.cancel) begin
			pending_d = 1'b0;
			phase_d   = 1'b0;
			rem_d     = '0;
		end else if (hit) begin
			pending_d = 1'b1;
			count_d   = count_q + dpg_pkg::COUNT_BITS'(1);
			stamp_d   = tick_time;
			if (delay_sat != '0) begin
				phase_d = 1'b0;
				rem_d   = delay_sat;
			end else if (width_sat != '0) begin
				phase_d = 1'b1;
				rem_d   = width_sat;
			end else begin
				pending_d = 1'b0;
				phase_d   = 1'b0;
				rem_d     = '0;
			end
		end else if (ctl.tick && pending_q) begin
			rem_d = rem_dec;
			if (rem_dec == '0) begin
				if (phase_q || width_sat == '0) begin
					pending_d = 1'b0;
					phase_d   = 1'b0;
					rem_d     = '0;
				end else begin
					phase_d = 1'b1;
					rem_d   = width_sat;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			phase_q   <= 1'b0;
			rem_q     <= '0;
			count_q   <= '0;
			stamp_q   <= '0;
		end else begin
			pending_q <= pending_d;
			phase_q   <= phase_d;
			rem_q     <= rem_d;
			count_q   <= count_d;
			stamp_q   <= stamp_d;
		end
	end

	assign mcfg.enable   = setup_q.enable;
	assign mcfg.edge_sel = setup_q.edge_sel;
	assign mcfg.pin      = setup_q.pin;
	assign pending       = pending_q;

	assign stat.level   = (pending_d && phase_d) ? setup_q.act_level : setup_q.idle_level;
	assign stat.pending = pending_d;
	assign stat.count   = count_d;
	assign stat.stamp   = stamp_d;

	`DPG_ASSERT(a_pending_count, !pending_q || rem_q != '0, "pending channel with zero count")
	`DPG_ASSERT(a_idle_phase, pending_q || !phase_q, "pulse phase on an idle channel")

endmodule

/* design/edge_triggered_delayed_pulse_generator.sv */
// ----------------------------------------------------------------------------
// edge_triggered_delayed_pulse_generator
// Multi-channel trigger delay generator driven by tick, edge and arm words.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel: one word per tick of the microsecond time base, pin edge
//   event, arm or disarm command. The word is taken on a rising edge with
//   cmd_valid high and cmd_stall low.
//   rsp channel: one word per command word, carrying the output levels,
//   pending flags, armed state, whether an edge scheduled a pulse, and the
//   event count and last timestamp of the channel chosen by status_channel.
//   Path: a taken word lands in the input register, and its result is
//   loaded into the result register when the word moves on.
//   Throughput: one word per cycle while rsp_stall is low; the input
//   register and the result register each hold one word, so a new word is
//   taken while a finished result waits. cmd_stall rises only when both
//   registers are full and the receiver holds rsp_stall high.
//   cfg port: cfg_wr_en writes cfg_data into the channel setup named by
//   cfg_index; write only while no word is in flight.
//   Reset: disarmed, all channels idle, counts, stamps and tick time zero,
//   setups at their defaults (no delay, 100 tick pulse, pin 2 + channel).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edge_triggered_delayed_pulse_generator #(
	parameter int NUM_CHANNELS    = 4,
	parameter int TICK_COUNT_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  dpg_pkg::cmd_t                        cmd,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output dpg_pkg::rsp_t                        rsp,
	input  logic                                 cfg_wr_en,
	input  logic [dpg_pkg::REG_INDEX_BITS-1:0]   cfg_index,
	input  logic [dpg_pkg::SETUP_BITS-1:0]       cfg_data
);

	// Input register
	logic                 valid_s1;
	dpg_pkg::cmd_t        cmd_s1;
	// Result register
	logic                 rsp_valid_q;
	dpg_pkg::rsp_t        rsp_q;
	// Block state
	logic                 armed_q, armed_d;
	logic [dpg_pkg::STAMP_BITS-1:0] tick_time_q;

	logic                 advance;
	logic                 cmd_take;
	logic                 edge_in;
	dpg_pkg::chan_ctl_t   ctl;
	logic                 accepted;

	logic [NUM_CHANNELS-1:0]                  cfg_wr;
	logic [NUM_CHANNELS-1:0]                  hit;
	logic [NUM_CHANNELS-1:0]                  pending;
	dpg_pkg::match_cfg_t [NUM_CHANNELS-1:0]   mcfg;
	dpg_pkg::chan_stat_t [NUM_CHANNELS-1:0]   stat;

	logic [dpg_pkg::OUT_CHANNELS-1:0]   levels_d, pend_d;
	logic [dpg_pkg::COUNT_BITS-1:0]     count_sel;
	logic [dpg_pkg::STAMP_BITS-1:0]     stamp_sel;

	// Move the held word on when the result register is empty or being emptied
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign cmd_take  = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1 <= cmd;
		end
	end

	// Decode the held word
	assign edge_in    = advance && (cmd_s1.operation == dpg_pkg::OP_EDGE);
	assign ctl.tick   = advance && (cmd_s1.operation == dpg_pkg::OP_TICK);
	assign ctl.cancel = advance && ((cmd_s1.operation == dpg_pkg::OP_ARM) ||
		(cmd_s1.operation == dpg_pkg::OP_DISARM));

	always_comb begin
		armed_d = armed_q;
		if (advance) begin
			case (cmd_s1.operation)
				dpg_pkg::OP_ARM:    armed_d = 1'b1;
				dpg_pkg::OP_DISARM: armed_d = 1'b0;
				default:            armed_d = armed_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			tick_time_q <= '0;
		end else begin
			armed_q <= armed_d;
			if (ctl.tick) begin
				tick_time_q <= tick_time_q + dpg_pkg::STAMP_BITS'(1);
			end
		end
	end

	// Route setup writes; channels past the register list keep their defaults
	always_comb begin
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			cfg_wr[ch] = cfg_wr_en && (ch < dpg_pkg::NUM_SETUP_REGS) &&
				(cfg_index == dpg_pkg::REG_INDEX_BITS'(ch));
		end
	end

	dpg_match #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_match (
		.edge_in   (edge_in),
		.armed     (armed_q),
		.event_pin (cmd_s1.event_pin),
		.rise_seen (cmd_s1.rise_seen),
		.fall_seen (cmd_s1.fall_seen),
		.cfg       (mcfg),
		.pending   (pending),
		.hit       (hit),
		.accepted  (accepted)
	);

	generate
		for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
			dpg_channel #(
				.CH_INDEX        (g),
				.TICK_COUNT_BITS (TICK_COUNT_BITS)
			) u_chan (
				.clk       (clk),
				.arst_n    (arst_n),
				.cfg_wr    (cfg_wr[g]),
				.cfg_data  (cfg_data),
				.ctl       (ctl),
				.hit       (hit[g]),
				.tick_time (tick_time_q),
				.mcfg      (mcfg[g]),
				.pending   (pending[g]),
				.stat      (stat[g])
			);
		end

		// Report only the first four channels in the flag fields
		for (genvar g = 0; g < dpg_pkg::OUT_CHANNELS; g++) begin : g_flags
			if (g < NUM_CHANNELS) begin : g_used
				assign levels_d[g] = stat[g].level;
				assign pend_d[g]   = stat[g].pending;
			end else begin : g_absent
				assign levels_d[g] = 1'b0;
				assign pend_d[g]   = 1'b0;
			end
		end
	endgenerate

	// Pick the status channel; a channel that does not exist reads zero
	always_comb begin
		count_sel = '0;
		stamp_sel = '0;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			if (ch < dpg_pkg::OUT_CHANNELS && cmd_s1.status_channel == 2'(ch)) begin
				count_sel = stat[ch].count;
				stamp_sel = stat[ch].stamp;
			end
		end
	end

	// Result register: load on advance, drop once the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.output_levels           <= levels_d;
			rsp_q.pending_flags           <= pend_d;
			rsp_q.is_armed                <= armed_d;
			rsp_q.accepted                <= accepted;
			rsp_q.channel_event_count     <= count_sel;
			rsp_q.channel_last_event_time <= stamp_sel;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`DPG_ASSERT(a_hit_onehot, $onehot0(hit), "edge word routed to more than one channel")
	`DPG_ASSERT_NEXT(a_adv_rsp, advance, rsp_valid_q, "advanced word left no result")
	`DPG_ASSERT_NEXT(a_tick_time, ctl.tick, tick_time_q == $past(tick_time_q) + 64'd1,
		"tick time did not advance by one")

endmodule
